// File: hdl/sjas_pkg.sv
// sjas_pkg: shared types, constants and tables for the skeleton joint angle statistics unit
// used by sjas_ctrl, sjas_dp and skeleton_joint_angle_stats_unit; depends on nothing
package sjas_pkg;

	// run limits and cordic depth
	localparam int MAX_FRAMES        = 4096;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int ATAN_LEN          = 24;
	localparam int CORDIC_N = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;

	// field and datapath widths
	localparam int JI_W    = 5;
	localparam int POS_W   = 16;
	localparam int VEC_W   = 17;
	localparam int ACC_W   = 36;
	localparam int ANG_W   = 15;
	localparam int ANG_MAX = 18000;
	localparam int FC_W    = $clog2(MAX_FRAMES + 1);
	localparam int SUM_W   = $clog2(MAX_FRAMES * ANG_MAX + 1);
	localparam int CQ_W    = 30;
	localparam int DQ_W    = (SUM_W > CQ_W) ? SUM_W : CQ_W;
	localparam int DEN_W   = 36;
	localparam int LEN_W   = 18;
	localparam int C_W     = 31;
	localparam int CC_W    = 62;
	localparam int SQ_W    = 61;
	localparam int CX_W    = 34;
	localparam int Z_W     = 32;
	localparam int STEP_W  = 5;

	// iteration counts of the shared units
	localparam int SQRT_STEPS = 31;
	localparam int DIVC_STEPS = CQ_W;

	// result kinds
	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_MAX   = 2'd1;
	localparam logic [1:0] KIND_MEAN  = 2'd2;

	// stored joint numbers
	localparam logic [JI_W-1:0] J_SPINE_BASE = 5'd0;
	localparam logic [JI_W-1:0] J_NECK       = 5'd3;
	localparam logic [JI_W-1:0] J_SHOULDER_R = 5'd12;
	localparam logic [JI_W-1:0] J_ELBOW_R    = 5'd13;
	localparam logic [JI_W-1:0] J_HIP_L      = 5'd18;
	localparam logic [JI_W-1:0] J_KNEE_L     = 5'd19;
	localparam logic [JI_W-1:0] J_ANKLE_L    = 5'd20;

	typedef struct packed {
		logic [JI_W-1:0]         joint_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic                    frame_last;
		logic                    run_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ANG_W-1:0] arm_angle;
		logic [ANG_W-1:0] thigh_angle;
		logic [ANG_W-1:0] shank_angle;
		logic [2:0]       degenerate_mask;
		logic             last;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_VEC, OP_MAC_DOT, OP_MAC_NA, OP_MAC_NB, OP_ZERO,
		OP_SQ_NA, OP_SQ_NB, OP_SQ_S, OP_SQ_STEP, OP_LB, OP_DEN, OP_DIV_C,
		OP_DIV_STEP, OP_CSAVE, OP_CC, OP_CORD_LD, OP_CORD_STEP, OP_FIN, OP_ACC,
		OP_OUT_FRAME, OP_DIV_M, OP_MSAVE, OP_OUT_MAX, OP_OUT_MEAN, OP_RUN_CLR
	} op_t;

	typedef enum logic [5:0] {
		S_IDLE, S_VEC, S_MDOT, S_MNA, S_MNB, S_CHK, S_ZERO,
		S_SA_LD, S_SA_RUN, S_SB_LD, S_SB_RUN, S_LB, S_DEN,
		S_DC_LD, S_DC_RUN, S_CSAVE, S_CC, S_SS_LD, S_SS_RUN,
		S_CORD_LD, S_CORD_RUN, S_FIN, S_ACC, S_OUT_F, S_EMIT_F,
		S_DM_LD, S_DM_RUN, S_MSAVE, S_OUT_M, S_EMIT_M, S_OUT_A, S_EMIT_A
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [1:0]        k;
		logic [STEP_W-1:0] step;
		logic              run_end;
	} cmd_t;

	typedef struct packed {
		logic vec_zero;
	} stat_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/sjas_ctrl.sv
// sjas_ctrl: sequencing state machine of the joint angle statistics unit
// depends on sjas_pkg; drives sjas_dp through cmd_t and reads stat_t
module sjas_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                frame_last,
	input  logic                run_last,
	output logic                out_valid,
	input  logic                out_ready,
	input  sjas_pkg::stat_t     stat,
	output sjas_pkg::cmd_t      cmd
);

	sjas_pkg::state_t              state_q, state_d;
	logic [1:0]                    k_q, k_d;
	logic [sjas_pkg::STEP_W-1:0]   cnt_q, cnt_d;
	logic                          rl_q, rl_d;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sjas_pkg::S_IDLE;
			k_q     <= 2'd0;
			cnt_q   <= '0;
			rl_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			cnt_q   <= cnt_d;
			rl_q    <= rl_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		cnt_d       = cnt_q;
		rl_d        = rl_q;
		cmd.op      = sjas_pkg::OP_NONE;
		cmd.k       = k_q;
		cmd.step    = cnt_q;
		cmd.run_end = rl_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		case (state_q)
			sjas_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = sjas_pkg::OP_LOAD;
					if (frame_last) begin
						rl_d    = run_last;
						state_d = sjas_pkg::S_VEC;
					end
				end
			end
			sjas_pkg::S_VEC: begin
				cmd.op  = sjas_pkg::OP_VEC;
				k_d     = 2'd0;
				cnt_d   = '0;
				state_d = sjas_pkg::S_MDOT;
			end
			sjas_pkg::S_MDOT, sjas_pkg::S_MNA, sjas_pkg::S_MNB: begin
				if (state_q == sjas_pkg::S_MDOT) cmd.op = sjas_pkg::OP_MAC_DOT;
				else if (state_q == sjas_pkg::S_MNA) cmd.op = sjas_pkg::OP_MAC_NA;
				else cmd.op = sjas_pkg::OP_MAC_NB;
				if (cnt_q == sjas_pkg::STEP_W'(2)) begin
					cnt_d = '0;
					if (state_q == sjas_pkg::S_MDOT) state_d = sjas_pkg::S_MNA;
					else if (state_q == sjas_pkg::S_MNA) state_d = sjas_pkg::S_MNB;
					else state_d = sjas_pkg::S_CHK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			sjas_pkg::S_CHK: begin
				state_d = stat.vec_zero ? sjas_pkg::S_ZERO : sjas_pkg::S_SA_LD;
			end
			sjas_pkg::S_SA_LD: begin
				cmd.op  = sjas_pkg::OP_SQ_NA;
				state_d = sjas_pkg::S_SA_RUN;
			end
			sjas_pkg::S_SB_LD: begin
				cmd.op  = sjas_pkg::OP_SQ_NB;
				state_d = sjas_pkg::S_SB_RUN;
			end
			sjas_pkg::S_SS_LD: begin
				cmd.op  = sjas_pkg::OP_SQ_S;
				state_d = sjas_pkg::S_SS_RUN;
			end
			// square root iterations, shared by three operands
			sjas_pkg::S_SA_RUN, sjas_pkg::S_SB_RUN, sjas_pkg::S_SS_RUN: begin
				cmd.op = sjas_pkg::OP_SQ_STEP;
				if (cnt_q == sjas_pkg::STEP_W'(sjas_pkg::SQRT_STEPS - 1)) begin
					cnt_d = '0;
					if (state_q == sjas_pkg::S_SA_RUN) state_d = sjas_pkg::S_SB_LD;
					else if (state_q == sjas_pkg::S_SB_RUN) state_d = sjas_pkg::S_LB;
					else state_d = sjas_pkg::S_CORD_LD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			sjas_pkg::S_LB: begin
				cmd.op  = sjas_pkg::OP_LB;
				state_d = sjas_pkg::S_DEN;
			end
			sjas_pkg::S_DEN: begin
				cmd.op  = sjas_pkg::OP_DEN;
				state_d = sjas_pkg::S_DC_LD;
			end
			sjas_pkg::S_DC_LD: begin
				cmd.op  = sjas_pkg::OP_DIV_C;
				state_d = sjas_pkg::S_DC_RUN;
			end
			sjas_pkg::S_DC_RUN: begin
				cmd.op = sjas_pkg::OP_DIV_STEP;
				if (cnt_q == sjas_pkg::STEP_W'(sjas_pkg::DIVC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = sjas_pkg::S_CSAVE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			sjas_pkg::S_CSAVE: begin
				cmd.op  = sjas_pkg::OP_CSAVE;
				state_d = sjas_pkg::S_CC;
			end
			sjas_pkg::S_CC: begin
				cmd.op  = sjas_pkg::OP_CC;
				state_d = sjas_pkg::S_SS_LD;
			end
			sjas_pkg::S_CORD_LD: begin
				cmd.op  = sjas_pkg::OP_CORD_LD;
				state_d = sjas_pkg::S_CORD_RUN;
			end
			sjas_pkg::S_CORD_RUN: begin
				cmd.op = sjas_pkg::OP_CORD_STEP;
				if (cnt_q == sjas_pkg::STEP_W'(sjas_pkg::CORDIC_N - 1)) begin
					cnt_d   = '0;
					state_d = sjas_pkg::S_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			// one angle done, move to the next limb
			sjas_pkg::S_ZERO, sjas_pkg::S_FIN: begin
				cmd.op = (state_q == sjas_pkg::S_ZERO) ? sjas_pkg::OP_ZERO : sjas_pkg::OP_FIN;
				if (k_q == 2'd2) begin
					state_d = sjas_pkg::S_ACC;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = sjas_pkg::S_MDOT;
				end
			end
			sjas_pkg::S_ACC: begin
				cmd.op  = sjas_pkg::OP_ACC;
				state_d = sjas_pkg::S_OUT_F;
			end
			sjas_pkg::S_OUT_F: begin
				cmd.op  = sjas_pkg::OP_OUT_FRAME;
				state_d = sjas_pkg::S_EMIT_F;
			end
			sjas_pkg::S_EMIT_F: begin
				out_valid = 1'b1;
				if (out_ready) begin
					k_d     = 2'd0;
					state_d = rl_q ? sjas_pkg::S_DM_LD : sjas_pkg::S_IDLE;
				end
			end
			// run means, one division per angle
			sjas_pkg::S_DM_LD: begin
				cmd.op  = sjas_pkg::OP_DIV_M;
				state_d = sjas_pkg::S_DM_RUN;
			end
			sjas_pkg::S_DM_RUN: begin
				cmd.op = sjas_pkg::OP_DIV_STEP;
				if (cnt_q == sjas_pkg::STEP_W'(sjas_pkg::SUM_W - 1)) begin
					cnt_d   = '0;
					state_d = sjas_pkg::S_MSAVE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			sjas_pkg::S_MSAVE: begin
				cmd.op = sjas_pkg::OP_MSAVE;
				if (k_q == 2'd2) begin
					state_d = sjas_pkg::S_OUT_M;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = sjas_pkg::S_DM_LD;
				end
			end
			sjas_pkg::S_OUT_M: begin
				cmd.op  = sjas_pkg::OP_OUT_MAX;
				state_d = sjas_pkg::S_EMIT_M;
			end
			sjas_pkg::S_EMIT_M: begin
				out_valid = 1'b1;
				if (out_ready) state_d = sjas_pkg::S_OUT_A;
			end
			sjas_pkg::S_OUT_A: begin
				cmd.op  = sjas_pkg::OP_OUT_MEAN;
				state_d = sjas_pkg::S_EMIT_A;
			end
			sjas_pkg::S_EMIT_A: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.op  = sjas_pkg::OP_RUN_CLR;
					state_d = sjas_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sjas_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/sjas_dp.sv
// sjas_dp: datapath of the joint angle statistics unit: joint store, multiply-accumulate,
// shared square root, divider and cordic, run statistics and result register; uses sjas_pkg
module sjas_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sjas_pkg::cmd_t      cmd,
	input  sjas_pkg::in_item_t  in_item,
	output sjas_pkg::stat_t     stat,
	output sjas_pkg::out_item_t out_item
);

	localparam logic [sjas_pkg::SQ_W-1:0] SQ_TOP = sjas_pkg::SQ_W'(1) << 60;
	localparam logic [sjas_pkg::C_W-1:0]  C_ONE  = sjas_pkg::C_W'(1) << 30;
	localparam logic signed [sjas_pkg::CX_W-1:0] Z_ONE = sjas_pkg::CX_W'(1) << 30;
	localparam logic [sjas_pkg::Z_W-1:0]  Z_HALF = sjas_pkg::Z_W'(1) << 31;
	localparam logic [47:0]               RND    = 48'd1 << 31;

	logic signed [sjas_pkg::POS_W-1:0] js_q [7][3];
	logic signed [sjas_pkg::VEC_W-1:0] trunk_q [3];
	logic signed [sjas_pkg::VEC_W-1:0] limb_q [3][3];
	logic signed [sjas_pkg::ACC_W-1:0] dot_q, na_q, nb_q;
	logic [sjas_pkg::SQ_W-1:0]         sq_v_q, sq_r_q, sq_b_q;
	logic [sjas_pkg::LEN_W-1:0]        la_q, lb_q;
	logic [sjas_pkg::DEN_W-1:0]        den_q, rem_q;
	logic [sjas_pkg::DQ_W-1:0]         qd_q;
	logic                              sat_q;
	logic [sjas_pkg::C_W-1:0]          c_q;
	logic [sjas_pkg::CC_W-1:0]         cc_q;
	logic signed [sjas_pkg::CX_W-1:0]  cx_q, cy_q, cz_q;
	logic [sjas_pkg::ANG_W-1:0]        ang_q [3];
	logic [2:0]                        mask_q;
	logic [sjas_pkg::ANG_W-1:0]        max_q [3];
	logic [sjas_pkg::SUM_W-1:0]        sum_q [3];
	logic [sjas_pkg::ANG_W-1:0]        mean_q [3];
	logic [sjas_pkg::FC_W-1:0]         fc_q;
	sjas_pkg::out_item_t               out_q;

	// slot decode of the incoming joint
	logic       slot_ok;
	logic [2:0] slot;
	always_comb begin
		slot_ok = 1'b1;
		slot    = 3'd0;
		case (in_item.joint_index)
			sjas_pkg::J_SPINE_BASE: slot = 3'd0;
			sjas_pkg::J_NECK:       slot = 3'd1;
			sjas_pkg::J_SHOULDER_R: slot = 3'd2;
			sjas_pkg::J_ELBOW_R:    slot = 3'd3;
			sjas_pkg::J_HIP_L:      slot = 3'd4;
			sjas_pkg::J_KNEE_L:     slot = 3'd5;
			sjas_pkg::J_ANKLE_L:    slot = 3'd6;
			default:                slot_ok = 1'b0;
		endcase
	end

	// multiply-accumulate operands
	logic [1:0]                          ci;
	logic signed [sjas_pkg::VEC_W-1:0]   ta, lbv, ma, mb;
	logic signed [2*sjas_pkg::VEC_W-1:0] prod;
	logic signed [sjas_pkg::ACC_W-1:0]   prod_x;
	always_comb begin
		ci  = cmd.step[1:0];
		ta  = trunk_q[0];
		lbv = limb_q[cmd.k][0];
		case (ci)
			2'd1: begin
				ta  = trunk_q[1];
				lbv = limb_q[cmd.k][1];
			end
			2'd2: begin
				ta  = trunk_q[2];
				lbv = limb_q[cmd.k][2];
			end
			default: ;
		endcase
		ma = (cmd.op == sjas_pkg::OP_MAC_NB) ? lbv : ta;
		mb = (cmd.op == sjas_pkg::OP_MAC_NA) ? ta : lbv;
		prod   = ma * mb;
		prod_x = sjas_pkg::ACC_W'(prod);
	end

	assign stat.vec_zero = (na_q == '0) || (nb_q == '0);

	// dot magnitude and cosine saturation
	logic [sjas_pkg::DEN_W-1:0] mag;
	assign mag = dot_q[sjas_pkg::ACC_W-1] ? sjas_pkg::DEN_W'(-dot_q) : sjas_pkg::DEN_W'(dot_q);

	// square root step
	logic [sjas_pkg::SQ_W-1:0] sq_t;
	assign sq_t = sq_r_q + sq_b_q;

	// divider step
	logic [sjas_pkg::DEN_W-1:0] dv_sh;
	logic                       dv_ge;
	assign dv_sh = {rem_q[sjas_pkg::DEN_W-2:0], qd_q[sjas_pkg::DQ_W-1]};
	assign dv_ge = dv_sh >= den_q;

	// cordic step
	logic signed [sjas_pkg::CX_W-1:0] xs, ys, at;
	assign xs = cx_q >>> cmd.step;
	assign ys = cy_q >>> cmd.step;
	assign at = sjas_pkg::CX_W'(sjas_pkg::atan_turn(cmd.step));

	// angle clamp, mirror and scaling to hundredths of a degree
	logic [sjas_pkg::Z_W-1:0] zc, zm;
	logic [47:0]              hprod;
	always_comb begin
		if (cz_q < 0) zc = '0;
		else if (cz_q > Z_ONE) zc = sjas_pkg::Z_W'(Z_ONE);
		else zc = sjas_pkg::Z_W'(cz_q);
		zm    = dot_q[sjas_pkg::ACC_W-1] ? (Z_HALF - zc) : zc;
		hprod = 48'(zm) * 48'd36000 + RND;
	end

	// joint store, kept across runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 7; i++) begin
				for (int j = 0; j < 3; j++) js_q[i][j] <= '0;
			end
		end else if (cmd.op == sjas_pkg::OP_LOAD && slot_ok) begin
			js_q[slot][0] <= in_item.pos_x;
			js_q[slot][1] <= in_item.pos_y;
			js_q[slot][2] <= in_item.pos_z;
		end
	end

	// run statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
			for (int i = 0; i < 3; i++) begin
				max_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else if (cmd.op == sjas_pkg::OP_ACC) begin
			if (fc_q < sjas_pkg::FC_W'(sjas_pkg::MAX_FRAMES)) begin
				for (int i = 0; i < 3; i++) begin
					if (fc_q == '0 || ang_q[i] > max_q[i]) max_q[i] <= ang_q[i];
					sum_q[i] <= sum_q[i] + sjas_pkg::SUM_W'(ang_q[i]);
				end
				fc_q <= fc_q + 1'b1;
			end
		end else if (cmd.op == sjas_pkg::OP_RUN_CLR) begin
			fc_q <= '0;
			for (int i = 0; i < 3; i++) begin
				max_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			sjas_pkg::OP_VEC: begin
				mask_q <= 3'd0;
				for (int j = 0; j < 3; j++) begin
					trunk_q[j]   <= sjas_pkg::VEC_W'(js_q[0][j]) - sjas_pkg::VEC_W'(js_q[1][j]);
					limb_q[0][j] <= sjas_pkg::VEC_W'(js_q[3][j]) - sjas_pkg::VEC_W'(js_q[2][j]);
					limb_q[1][j] <= sjas_pkg::VEC_W'(js_q[5][j]) - sjas_pkg::VEC_W'(js_q[4][j]);
					limb_q[2][j] <= sjas_pkg::VEC_W'(js_q[6][j]) - sjas_pkg::VEC_W'(js_q[5][j]);
				end
			end
			sjas_pkg::OP_MAC_DOT: dot_q <= (ci == 2'd0) ? prod_x : dot_q + prod_x;
			sjas_pkg::OP_MAC_NA:  na_q  <= (ci == 2'd0) ? prod_x : na_q + prod_x;
			sjas_pkg::OP_MAC_NB:  nb_q  <= (ci == 2'd0) ? prod_x : nb_q + prod_x;
			sjas_pkg::OP_ZERO: begin
				ang_q[cmd.k]  <= '0;
				mask_q[cmd.k] <= 1'b1;
			end
			sjas_pkg::OP_SQ_NA: begin
				sq_v_q <= sjas_pkg::SQ_W'(unsigned'(na_q));
				sq_r_q <= '0;
				sq_b_q <= SQ_TOP;
			end
			sjas_pkg::OP_SQ_NB: begin
				la_q   <= sq_r_q[sjas_pkg::LEN_W-1:0];
				sq_v_q <= sjas_pkg::SQ_W'(unsigned'(nb_q));
				sq_r_q <= '0;
				sq_b_q <= SQ_TOP;
			end
			sjas_pkg::OP_SQ_S: begin
				sq_v_q <= SQ_TOP - cc_q[sjas_pkg::SQ_W-1:0];
				sq_r_q <= '0;
				sq_b_q <= SQ_TOP;
			end
			sjas_pkg::OP_SQ_STEP: begin
				if (sq_v_q >= sq_t) begin
					sq_v_q <= sq_v_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_b_q <= sq_b_q >> 2;
			end
			sjas_pkg::OP_LB:  lb_q  <= sq_r_q[sjas_pkg::LEN_W-1:0];
			sjas_pkg::OP_DEN: den_q <= sjas_pkg::DEN_W'(la_q * lb_q);
			sjas_pkg::OP_DIV_C: begin
				sat_q <= mag >= den_q;
				rem_q <= mag;
				qd_q  <= '0;
			end
			sjas_pkg::OP_DIV_M: begin
				den_q <= sjas_pkg::DEN_W'(fc_q);
				rem_q <= '0;
				qd_q  <= sjas_pkg::DQ_W'(sum_q[cmd.k]) << (sjas_pkg::DQ_W - sjas_pkg::SUM_W);
			end
			sjas_pkg::OP_DIV_STEP: begin
				rem_q <= dv_ge ? dv_sh - den_q : dv_sh;
				qd_q  <= {qd_q[sjas_pkg::DQ_W-2:0], dv_ge};
			end
			sjas_pkg::OP_CSAVE: c_q <= sat_q ? C_ONE : sjas_pkg::C_W'(qd_q[sjas_pkg::CQ_W-1:0]);
			sjas_pkg::OP_CC:    cc_q <= sjas_pkg::CC_W'(c_q) * sjas_pkg::CC_W'(c_q);
			sjas_pkg::OP_CORD_LD: begin
				cx_q <= sjas_pkg::CX_W'(c_q);
				cy_q <= sjas_pkg::CX_W'(sq_r_q[sjas_pkg::C_W-1:0]);
				cz_q <= '0;
			end
			sjas_pkg::OP_CORD_STEP: begin
				if (!cy_q[sjas_pkg::CX_W-1]) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end
			end
			sjas_pkg::OP_FIN:   ang_q[cmd.k]  <= hprod[46:32];
			sjas_pkg::OP_MSAVE: mean_q[cmd.k] <= qd_q[sjas_pkg::ANG_W-1:0];
			sjas_pkg::OP_OUT_FRAME: begin
				out_q.kind            <= sjas_pkg::KIND_FRAME;
				out_q.arm_angle       <= ang_q[0];
				out_q.thigh_angle     <= ang_q[1];
				out_q.shank_angle     <= ang_q[2];
				out_q.degenerate_mask <= mask_q;
				out_q.last            <= !cmd.run_end;
			end
			sjas_pkg::OP_OUT_MAX: begin
				out_q.kind            <= sjas_pkg::KIND_MAX;
				out_q.arm_angle       <= max_q[0];
				out_q.thigh_angle     <= max_q[1];
				out_q.shank_angle     <= max_q[2];
				out_q.degenerate_mask <= 3'd0;
				out_q.last            <= 1'b0;
			end
			sjas_pkg::OP_OUT_MEAN: begin
				out_q.kind            <= sjas_pkg::KIND_MEAN;
				out_q.arm_angle       <= mean_q[0];
				out_q.thigh_angle     <= mean_q[1];
				out_q.shank_angle     <= mean_q[2];
				out_q.degenerate_mask <= 3'd0;
				out_q.last            <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_item = out_q;

endmodule

// File: hdl/skeleton_joint_angle_stats_unit.sv
// skeleton_joint_angle_stats_unit: top level of the joint angle statistics unit
// depends on sjas_pkg, sjas_ctrl and sjas_dp
//
// Joint items that do not end a frame are taken in the idle state and only update the
// joint store. An item that ends a frame starts the angle work: for each of the three
// limb angles a serial multiply-accumulate, two 31-step square roots, a 30-step divider,
// one more 31-step square root for the sine and a CORDIC_ITERATIONS-step cordic, all on
// one shared set of iterative units; the square roots, divider and cordic are skipped
// when a vector has zero length. The frame result is offered once all three angles are
// done, and the input is not ready again until the frame result has been taken. When the
// item also ends the run, three SUM_W-step divisions form the means, then the maxima and
// the means follow as two more items. The joint store is kept across runs.
module skeleton_joint_angle_stats_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sjas_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output sjas_pkg::out_item_t out_item
);

	sjas_pkg::cmd_t  cmd;
	sjas_pkg::stat_t stat;

	// sequencer
	sjas_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_last (in_item.frame_last),
		.run_last   (in_item.run_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath
	sjas_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule

// File: sim/skeleton_joint_angle_stats_unit_chk.sv
// skeleton_joint_angle_stats_unit_chk: watches both channels, predicts frame angles and run
// statistics, and compares every result item; depends on sjas_pkg
`timescale 1ns / 1ps
module skeleton_joint_angle_stats_unit_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  sjas_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  sjas_pkg::out_item_t out_item,
	output int                  errors,
	output int                  pending
);

	typedef longint vec3_t [3];

	// arctangent of 2^-i, 2^-32 turn
	localparam longint ATAN_TURNS [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};

	sjas_pkg::out_item_t expected_q [$];
	longint              joint_pos [7][3];
	logic [14:0]         angle_max [3];
	longint              angle_sum [3];
	int                  frames_in_run;

	function automatic int store_slot(input logic [sjas_pkg::JI_W-1:0] j);
		case (j)
			sjas_pkg::J_SPINE_BASE: return 0;
			sjas_pkg::J_NECK:       return 1;
			sjas_pkg::J_SHOULDER_R: return 2;
			sjas_pkg::J_ELBOW_R:    return 3;
			sjas_pkg::J_HIP_L:      return 4;
			sjas_pkg::J_KNEE_L:     return 5;
			sjas_pkg::J_ANKLE_L:    return 6;
			default:                return -1;
		endcase
	endfunction

	// floor square root, inputs below 2^62
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 30; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// angle between two vectors in 0.01 degree; returns 1 on a zero-length vector
	function automatic bit pair_angle(input vec3_t a, input vec3_t b, output logic [14:0] hund);
		longint          dot, x, y, z, xs, ys, t;
		longint unsigned na2, nb2, den, mag, c, s, h;
		logic [95:0]     num;
		bit              neg;
		dot = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		na2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		nb2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
		hund = '0;
		if (na2 == 0 || nb2 == 0)
			return 1'b1;
		den = floor_sqrt(na2) * floor_sqrt(nb2);
		neg = dot < 0;
		mag = neg ? -dot : dot;
		if (mag >= den) begin
			c = 64'd1 << 30;
		end else begin
			num = {32'd0, mag} << 30;
			c = num / den;
		end
		s = floor_sqrt((64'd1 << 60) - c * c);
		x = c;
		y = s;
		z = 0;
		for (int i = 0; i < sjas_pkg::CORDIC_N; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				t = x + ys; y = y - xs; z += ATAN_TURNS[i];
			end else begin
				t = x - ys; y = y + xs; z -= ATAN_TURNS[i];
			end
			x = t;
		end
		if (z < 0) z = 0;
		if (z > (longint'(1) << 30)) z = longint'(1) << 30;
		if (neg) z = (longint'(1) << 31) - z;
		h = (longint'(z) * 36000 + (64'd1 << 31)) >> 32;
		hund = h[14:0];
		return 1'b0;
	endfunction

	task automatic predict_item(input sjas_pkg::in_item_t it);
		int                  sl;
		vec3_t               trunk, limb [3];
		logic [14:0]         ang [3];
		logic [2:0]          mask;
		sjas_pkg::out_item_t r;
		sl = store_slot(it.joint_index);
		if (sl >= 0) begin
			joint_pos[sl][0] = it.pos_x;
			joint_pos[sl][1] = it.pos_y;
			joint_pos[sl][2] = it.pos_z;
		end
		if (!it.frame_last)
			return;
		for (int k = 0; k < 3; k++) begin
			trunk[k]   = joint_pos[0][k] - joint_pos[1][k];
			limb[0][k] = joint_pos[3][k] - joint_pos[2][k];
			limb[1][k] = joint_pos[5][k] - joint_pos[4][k];
			limb[2][k] = joint_pos[6][k] - joint_pos[5][k];
		end
		mask = '0;
		for (int k = 0; k < 3; k++)
			mask[k] = pair_angle(trunk, limb[k], ang[k]);
		if (frames_in_run < sjas_pkg::MAX_FRAMES) begin
			for (int k = 0; k < 3; k++) begin
				if (frames_in_run == 0 || ang[k] > angle_max[k])
					angle_max[k] = ang[k];
				angle_sum[k] += ang[k];
			end
			frames_in_run++;
		end
		r = '{sjas_pkg::KIND_FRAME, ang[0], ang[1], ang[2], mask, !it.run_last};
		expected_q.push_back(r);
		if (!it.run_last)
			return;
		r = '{sjas_pkg::KIND_MAX, angle_max[0], angle_max[1], angle_max[2], 3'd0, 1'b0};
		expected_q.push_back(r);
		for (int k = 0; k < 3; k++)
			ang[k] = (frames_in_run != 0) ? angle_sum[k] / frames_in_run : 0;
		r = '{sjas_pkg::KIND_MEAN, ang[0], ang[1], ang[2], 3'd0, 1'b1};
		expected_q.push_back(r);
		for (int k = 0; k < 3; k++) begin
			angle_max[k] = '0;
			angle_sum[k] = 0;
		end
		frames_in_run = 0;
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: result mismatch on %s: got %0d, expected %0d", $realtime, what, got,
			want);
		errors++;
	endtask

	// clear the model in reset, else compare results, then predict from the accepted item
	always @(posedge clk) begin
		sjas_pkg::out_item_t w;
		if (!arst_n) begin
			expected_q.delete();
			frames_in_run = 0;
			for (int i = 0; i < 7; i++)
				for (int k = 0; k < 3; k++)
					joint_pos[i][k] = 0;
			for (int k = 0; k < 3; k++) begin
				angle_max[k] = '0;
				angle_sum[k] = 0;
			end
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result item, kind %0d", $realtime, out_item.kind);
					errors++;
				end else begin
					w = expected_q.pop_front();
					if (out_item.kind != w.kind) report("kind", out_item.kind, w.kind);
					if (out_item.arm_angle != w.arm_angle)
						report("arm_angle", out_item.arm_angle, w.arm_angle);
					if (out_item.thigh_angle != w.thigh_angle)
						report("thigh_angle", out_item.thigh_angle, w.thigh_angle);
					if (out_item.shank_angle != w.shank_angle)
						report("shank_angle", out_item.shank_angle, w.shank_angle);
					if (out_item.degenerate_mask != w.degenerate_mask)
						report("degenerate_mask", out_item.degenerate_mask,
							w.degenerate_mask);
					if (out_item.last != w.last) report("last", out_item.last, w.last);
				end
			end
			if (in_valid && in_ready)
				predict_item(in_item);
		end
		pending = expected_q.size();
	end

endmodule

// File: sim/skeleton_joint_angle_stats_unit_tb.sv
// skeleton_joint_angle_stats_unit_tb: stimulus, clock, reset and verdict for the unit
// depends on sjas_pkg, skeleton_joint_angle_stats_unit and skeleton_joint_angle_stats_unit_chk
`timescale 1ns / 1ps
module skeleton_joint_angle_stats_unit_tb;

	localparam int IDLE_LIMIT = 20000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	sjas_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_ready;
	sjas_pkg::out_item_t out_item;
	int                  errors;
	int                  pending;
	int                  sent;
	bit                  hold_out;
	bit                  random_out_stalls;

	skeleton_joint_angle_stats_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	skeleton_joint_angle_stats_unit_chk u_chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, mostly short, plus a forced hold-off window
	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
			end else if (random_out_stalls && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
				repeat (stall - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any accepted item
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("skeleton_joint_angle_stats_unit verification failed");
				$finish;
			end
		end
	end

	task automatic send_joint(input logic [sjas_pkg::JI_W-1:0] j, input int x, input int y,
		input int z, input bit fl, input bit rl);
		int gap;
		gap = 0;
		if (random_out_stalls && $urandom_range(0, 2) == 0)
			gap = ($urandom_range(0, 14) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= '{j, x[15:0], y[15:0], z[15:0], fl, rl};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	function automatic int rand_coord(input int mode);
		case (mode)
			0:       return $signed($urandom_range(0, 65535)) - 32768;
			1:       return $signed($urandom_range(0, 6)) - 3;
			default: return $signed($urandom_range(0, 400)) - 200;
		endcase
	endfunction

	// a frame of random stored and unstored joints, ended by a frame_last item
	task automatic send_frame(input bit rl);
		logic [sjas_pkg::JI_W-1:0] stored [7];
		logic [sjas_pkg::JI_W-1:0] jx;
		int n, mode;
		stored = '{sjas_pkg::J_SPINE_BASE, sjas_pkg::J_NECK, sjas_pkg::J_SHOULDER_R,
			sjas_pkg::J_ELBOW_R, sjas_pkg::J_HIP_L, sjas_pkg::J_KNEE_L, sjas_pkg::J_ANKLE_L};
		mode = $urandom_range(0, 2);
		n = $urandom_range(2, 9);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				jx = sjas_pkg::JI_W'($urandom_range(0, 31));
			else
				jx = stored[$urandom_range(0, 6)];
			send_joint(jx, rand_coord(mode), rand_coord(mode), rand_coord(mode), 1'b0,
				$urandom_range(0, 7) == 0);
		end
		if ($urandom_range(0, 1) == 0)
			jx = stored[$urandom_range(0, 6)];
		else
			jx = sjas_pkg::JI_W'($urandom_range(0, 31));
		send_joint(jx, rand_coord(mode), rand_coord(mode), rand_coord(mode), 1'b1, rl);
	endtask

	initial begin
		int hold_cycles;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		sent = 0;
		hold_out = 1'b0;
		random_out_stalls = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all joints zero after reset: every vector degenerate
		send_joint(5'd31, 0, 0, 0, 1'b1, 1'b0);
		// field extremes on the trunk and arm
		send_joint(sjas_pkg::J_SPINE_BASE, 32767, 32767, 32767, 1'b0, 1'b0);
		send_joint(sjas_pkg::J_NECK, -32768, -32768, -32768, 1'b0, 1'b0);
		send_joint(sjas_pkg::J_SHOULDER_R, -32768, -32768, -32768, 1'b0, 1'b0);
		send_joint(sjas_pkg::J_ELBOW_R, 32767, 32767, 32767, 1'b1, 1'b0);
		// parallel, antiparallel and perpendicular limbs
		send_joint(sjas_pkg::J_SPINE_BASE, 0, 100, 0, 1'b0, 1'b0);
		send_joint(sjas_pkg::J_NECK, 0, 0, 0, 1'b0, 1'b0);
		send_joint(sjas_pkg::J_SHOULDER_R, 0, 0, 0, 1'b0, 1'b0);
		send_joint(sjas_pkg::J_ELBOW_R, 0, -50, 0, 1'b0, 1'b0);
		send_joint(sjas_pkg::J_HIP_L, 0, 0, 0, 1'b0, 1'b0);
		send_joint(sjas_pkg::J_KNEE_L, 70, 0, 0, 1'b0, 1'b0);
		send_joint(sjas_pkg::J_ANKLE_L, 70, 30, 0, 1'b1, 1'b0);
		// run end without frame end is ignored
		send_joint(5'd7, 123, -456, 789, 1'b0, 1'b1);
		// zero thigh, then run end on an unstored joint
		send_joint(sjas_pkg::J_KNEE_L, 0, 0, 0, 1'b0, 1'b0);
		send_joint(5'd21, -1, 1, -1, 1'b1, 1'b1);
		// one-frame run with an extreme ankle position
		send_joint(sjas_pkg::J_ANKLE_L, -32768, 32767, -32768, 1'b1, 1'b1);
		drain_results();

		// random part with idles on both sides
		random_out_stalls = 1'b1;
		while (sent < 200)
			send_frame($urandom_range(0, 4) == 0);

		// long receiver hold-off while frames keep coming
		hold_out = 1'b1;
		fork
			begin
				hold_cycles = 0;
				while (hold_cycles < 2000) begin
					@(posedge clk);
					hold_cycles++;
				end
				hold_out = 1'b0;
			end
			begin
				send_frame(1'b0);
				send_frame(1'b1);
			end
		join
		drain_results();

		while (sent < 430)
			send_frame($urandom_range(0, 4) == 0);
		send_frame(1'b1);
		drain_results();
		repeat (600) @(posedge clk);

		if (errors == 0)
			$display("skeleton_joint_angle_stats_unit verification clean");
		else
			$display("skeleton_joint_angle_stats_unit verification failed");
		$finish;
	end

endmodule
